### design/sprite_pixel_blitter_assert.svh
// Assertion macros used by the sprite pixel blitter top level.
// Needs only the clock and reset names passed in by the including module.
`ifndef SPRITE_PIXEL_BLITTER_ASSERT_SVH
`define SPRITE_PIXEL_BLITTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spb_pkg.sv
// Shared types and constants for the sprite pixel blitter.
// No dependencies; imported by every module of the block.
package spb_pkg;

  localparam int DEF_MAX_FRAME_DIM  = 4096;
  localparam int DEF_MAX_SPRITE_DIM = 4096;

  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int ORIG_W  = 16;
  localparam int OFF_W   = 12;
  localparam int SDIM_W  = 13;
  localparam int RAD_W   = 11;
  localparam int COLOR_W = 32;
  localparam int ADDR_W  = 24;
  localparam int COORD_W = ORIG_W + 1;
  localparam int RGB_W   = 24;
  localparam int SQ_W    = 2 * OFF_W;
  localparam int RSQ_W   = 2 * RAD_W;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [7:0]       ALPHA_OPAQUE       = 8'hFF;

  typedef enum logic [CIDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_BITMAP = 2'd0,
    KIND_RECT   = 2'd1,
    KIND_CIRCLE = 2'd2
  } shape_kind_t;

  // Operands of the circle distance test: distances from the center.
  typedef struct packed {
    logic [OFF_W-1:0] abs_ex;
    logic [OFF_W-1:0] abs_ey;
    logic [RAD_W-1:0] radius;
  } circ_in_t;

endpackage

### design/sprite_pixel_blitter.sv
// Sprite pixel blitter top level: clipping, shape tests and frame addressing.
// Depends on spb_pkg, spb_circle and sprite_pixel_blitter_assert.svh.
//
//   Channel  Direction  Handshake          Transaction
//   in       input      in_valid/in_stall  one sprite fragment
//   out      output     out_valid/out_stall one write decision with address and color
//   cfg      input      cfg_wr_en          one frame size register write
//
// out_valid rises once a fragment has passed every register stage; one fragment is
// accepted every cycle unless a stalled result holds the pipeline.
// The four register stages are coordinate add, clip and squares, address multiply and
// distance compare, and address add into the output register.
// rst_n is synchronous and clears all valid bits and the frame size registers to 640x480.
// A stall on a waiting result freezes every stage together and is passed back as in_stall
// in the same cycle; nothing is dropped or repeated.
module sprite_pixel_blitter
  import spb_pkg::*;
#(
  parameter int MAX_FRAME_DIM  = DEF_MAX_FRAME_DIM,
  parameter int MAX_SPRITE_DIM = DEF_MAX_SPRITE_DIM
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration port
  input  logic                cfg_wr_en,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // Fragment input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_shape_kind,
  input  logic [ORIG_W-1:0]   in_origin_x,
  input  logic [ORIG_W-1:0]   in_origin_y,
  input  logic [OFF_W-1:0]    in_offset_x,
  input  logic [OFF_W-1:0]    in_offset_y,
  input  logic [SDIM_W-1:0]   in_sprite_width,
  input  logic [SDIM_W-1:0]   in_sprite_height,
  input  logic [RAD_W-1:0]    in_circle_radius,
  input  logic [COLOR_W-1:0]  in_shape_color,
  input  logic                in_fill_enable,
  input  logic [COLOR_W-1:0]  in_texel,
  // Pixel write output
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_write_enable,
  output logic [ADDR_W-1:0]   out_pixel_address,
  output logic [COLOR_W-1:0]  out_pixel_color
);

`include "sprite_pixel_blitter_assert.svh"

  // Saturated frame and sprite dimensions need enough bits to hold the maximum.
  localparam int FDW = $clog2(MAX_FRAME_DIM + 1);
  localparam int SDW = $clog2(MAX_SPRITE_DIM + 1);
  localparam int PW  = 2 * FDW;

  // ---------------------------------------------------------------------------
  // Config registers: the user must write only while the pipeline is empty; not enforced.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes above the supported maximum clamp to it for clipping and stride.
  logic [FDW-1:0] fw_sat, fh_sat;

  always_comb begin
    if (int'(frame_width_r) > MAX_FRAME_DIM) begin
      fw_sat = FDW'(MAX_FRAME_DIM);
    end else begin
      fw_sat = FDW'(frame_width_r);
    end
    if (int'(frame_height_r) > MAX_FRAME_DIM) begin
      fh_sat = FDW'(MAX_FRAME_DIM);
    end else begin
      fh_sat = FDW'(frame_height_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipeline advances as one unless a finished result
  // sits in the output register and the consumer stalls it.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------------------
  // Stage 1: frame coordinates, rectangle border test, bitmap alpha test and
  // distances from the circle center.
  // ---------------------------------------------------------------------------
  logic [SDW-1:0] sw_sat, sh_sat;
  logic           rect_hit_nxt;
  logic           alpha_nz_nxt;
  logic [RGB_W-1:0] color_nxt;
  logic signed [COORD_W-1:0] fx_nxt, fy_nxt;
  circ_in_t       circ_nxt;

  always_comb begin
    if (int'(in_sprite_width) > MAX_SPRITE_DIM) begin
      sw_sat = SDW'(MAX_SPRITE_DIM);
    end else begin
      sw_sat = SDW'(in_sprite_width);
    end
    if (int'(in_sprite_height) > MAX_SPRITE_DIM) begin
      sh_sat = SDW'(MAX_SPRITE_DIM);
    end else begin
      sh_sat = SDW'(in_sprite_height);
    end

    fx_nxt = $signed({in_origin_x[ORIG_W-1], in_origin_x}) +
             $signed({{(COORD_W-OFF_W){1'b0}}, in_offset_x});
    fy_nxt = $signed({in_origin_y[ORIG_W-1], in_origin_y}) +
             $signed({{(COORD_W-OFF_W){1'b0}}, in_offset_y});

    // A zero-sized rectangle fails the range test, so the border compare
    // against size minus one never matters there.
    rect_hit_nxt = (int'(in_offset_x) < int'(sw_sat)) &&
                   (int'(in_offset_y) < int'(sh_sat)) &&
                   (in_fill_enable || (in_offset_x == '0) || (in_offset_y == '0) ||
                    (int'(in_offset_x) == int'(sw_sat) - 1) ||
                    (int'(in_offset_y) == int'(sh_sat) - 1));

    alpha_nz_nxt = (in_texel[COLOR_W-1:RGB_W] != '0);

    if (in_shape_kind == KIND_BITMAP) begin
      color_nxt = in_texel[RGB_W-1:0];
    end else begin
      color_nxt = in_shape_color[RGB_W-1:0];
    end

    // The center sits at (radius, radius); only magnitudes are squared later.
    if ((OFF_W+1)'(in_offset_x) >= (OFF_W+1)'(in_circle_radius)) begin
      circ_nxt.abs_ex = OFF_W'((OFF_W+1)'(in_offset_x) - (OFF_W+1)'(in_circle_radius));
    end else begin
      circ_nxt.abs_ex = OFF_W'((OFF_W+1)'(in_circle_radius) - (OFF_W+1)'(in_offset_x));
    end
    if ((OFF_W+1)'(in_offset_y) >= (OFF_W+1)'(in_circle_radius)) begin
      circ_nxt.abs_ey = OFF_W'((OFF_W+1)'(in_offset_y) - (OFF_W+1)'(in_circle_radius));
    end else begin
      circ_nxt.abs_ey = OFF_W'((OFF_W+1)'(in_circle_radius) - (OFF_W+1)'(in_offset_y));
    end
    circ_nxt.radius = in_circle_radius;
  end

  logic                      s1_valid_r;
  logic [1:0]                s1_kind_r;
  logic signed [COORD_W-1:0] s1_fx_r, s1_fy_r;
  logic                      s1_rect_hit_r, s1_alpha_nz_r;
  logic [RGB_W-1:0]          s1_color_r;
  circ_in_t                  s1_circ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r     <= in_shape_kind;
      s1_fx_r       <= fx_nxt;
      s1_fy_r       <= fy_nxt;
      s1_rect_hit_r <= rect_hit_nxt;
      s1_alpha_nz_r <= alpha_nz_nxt;
      s1_color_r    <= color_nxt;
      s1_circ_r     <= circ_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: frame clipping. The circle unit squares its operands in parallel.
  // ---------------------------------------------------------------------------
  logic inside_nxt;

  assign inside_nxt = !s1_fx_r[COORD_W-1] && !s1_fy_r[COORD_W-1] &&
                      (int'(s1_fx_r) < int'(fw_sat)) && (int'(s1_fy_r) < int'(fh_sat));

  logic             s2_valid_r;
  logic [1:0]       s2_kind_r;
  logic             s2_inside_r, s2_rect_hit_r, s2_alpha_nz_r;
  logic [FDW-1:0]   s2_fx_r, s2_fy_r;
  logic [RGB_W-1:0] s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Inside the frame both coordinates are below the clamped size, so the low
  // bits carry them exactly; outside, the address is discarded anyway.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r     <= s1_kind_r;
      s2_inside_r   <= inside_nxt;
      s2_rect_hit_r <= s1_rect_hit_r;
      s2_alpha_nz_r <= s1_alpha_nz_r;
      s2_fx_r       <= s1_fx_r[FDW-1:0];
      s2_fy_r       <= s1_fy_r[FDW-1:0];
      s2_color_r    <= s1_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: row times stride. The circle unit finishes its compare here.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] prod_nxt;

  assign prod_nxt = PW'(s2_fy_r) * PW'(fw_sat);

  logic             s3_valid_r;
  logic [1:0]       s3_kind_r;
  logic             s3_inside_r, s3_rect_hit_r, s3_alpha_nz_r;
  logic [PW-1:0]    s3_prod_r;
  logic [FDW-1:0]   s3_fx_r;
  logic [RGB_W-1:0] s3_color_r;
  logic             circ_hit;

  spb_circle u_circle (
    .clk    (clk),
    .en     (en),
    .circ_i (s1_circ_r),
    .hit_o  (circ_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind_r     <= s2_kind_r;
      s3_inside_r   <= s2_inside_r;
      s3_rect_hit_r <= s2_rect_hit_r;
      s3_alpha_nz_r <= s2_alpha_nz_r;
      s3_prod_r     <= prod_nxt;
      s3_fx_r       <= s2_fx_r;
      s3_color_r    <= s2_color_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: draw decision and final address add into the output register.
  // The unused shape code never draws. A fragment that is not drawn reports
  // zero address and zero color.
  // ---------------------------------------------------------------------------
  logic              draw_nxt;
  logic              shape_hit;
  logic [31:0]       addr_sum;
  logic [ADDR_W-1:0] addr_nxt;
  logic [COLOR_W-1:0] color_out_nxt;

  always_comb begin
    case (s3_kind_r)
      KIND_BITMAP: shape_hit = s3_alpha_nz_r;
      KIND_RECT:   shape_hit = s3_rect_hit_r;
      KIND_CIRCLE: shape_hit = circ_hit;
      default:     shape_hit = 1'b0;
    endcase
    draw_nxt = s3_inside_r && shape_hit;
    addr_sum = 32'(s3_prod_r) + 32'(s3_fx_r);
    if (draw_nxt) begin
      addr_nxt      = addr_sum[ADDR_W-1:0];
      color_out_nxt = {ALPHA_OPAQUE, s3_color_r};
    end else begin
      addr_nxt      = '0;
      color_out_nxt = '0;
    end
  end

  logic               out_we_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_we_r    <= draw_nxt;
      out_addr_r  <= addr_nxt;
      out_color_r <= color_out_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SPB_ASSERT_NOW(a_quiet_when_not_drawn, clk, rst_n,
    out_valid_r && !out_we_r, (out_addr_r == '0) && (out_color_r == '0),
    "fragment not drawn but address or color nonzero")
  `SPB_ASSERT_NOW(a_opaque_when_drawn, clk, rst_n,
    out_valid_r && out_we_r, out_color_r[COLOR_W-1:RGB_W] == ALPHA_OPAQUE,
    "drawn pixel color is not opaque")
  `SPB_ASSERT_NEXT(a_stage_advance, clk, rst_n,
    en && s3_valid_r, out_valid_r,
    "fragment lost between stage three and the output register")
  `SPB_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst_n,
    !en, (s1_valid_r == $past(s1_valid_r)) && (s3_valid_r == $past(s3_valid_r)),
    "pipeline moved while the output was stalled")

endmodule

### design/spb_circle.sv
// Two-stage circle inclusion test: squares, then sum and compare.
// Depends on spb_pkg for widths and the operand struct.
module spb_circle
  import spb_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  circ_in_t circ_i,
  output logic     hit_o
);

  logic [SQ_W-1:0]  sq_x_nxt, sq_y_nxt;
  logic [RSQ_W-1:0] sq_r_nxt;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r;
  logic [RSQ_W-1:0] sq_r_r;
  logic             hit_r;
  logic             hit_nxt;

  assign sq_x_nxt = SQ_W'(circ_i.abs_ex) * SQ_W'(circ_i.abs_ex);
  assign sq_y_nxt = SQ_W'(circ_i.abs_ey) * SQ_W'(circ_i.abs_ey);
  assign sq_r_nxt = RSQ_W'(circ_i.radius) * RSQ_W'(circ_i.radius);

  // Sum needs one more bit than either square.
  assign hit_nxt = ((SQ_W+1)'(sq_x_r) + (SQ_W+1)'(sq_y_r)) <= (SQ_W+1)'(sq_r_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r <= sq_x_nxt;
      sq_y_r <= sq_y_nxt;
      sq_r_r <= sq_r_nxt;
      hit_r  <= hit_nxt;
    end
  end

  assign hit_o = hit_r;

endmodule
